[hdl/smt3p_pkg.sv]
//==============================================================================
// smt3p_pkg
// Types and constants shared by the spectrum magnitude / top-3 peak blocks.
//==============================================================================
`default_nettype none

package smt3p_pkg;

    localparam int BIN_W      = 9;
    localparam int MAG_W      = 17;
    localparam int WORD_W     = 32;
    localparam int HALF_W     = 16;
    localparam int SQ_W       = 31;
    localparam int SUM_W      = 32;
    localparam int RAD_W      = 34;
    localparam int REM_W      = 19;
    localparam int ROOT_STEPS = 17;
    localparam int STEP_W     = 5;
    localparam int MAX_BINS   = 512;
    localparam int FFT_POINTS_DEFAULT = 1024;

    typedef struct packed {
        logic [WORD_W-1:0] spectrum_word;
        logic              last_bin;
    } spec_in_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [BIN_W-1:0] bin_index;
        logic             frame_done;
        logic [BIN_W-1:0] first_peak_bin;
        logic [BIN_W-1:0] second_peak_bin;
        logic [BIN_W-1:0] third_peak_bin;
        logic [MAG_W-1:0] first_peak_magnitude;
    } spec_out_t;

    typedef struct packed {
        logic [WORD_W-1:0] spectrum_word;
        logic [BIN_W-1:0]  bin;
        logic              done;
    } bin_task_t;

endpackage

`default_nettype wire

[hdl/spectrum_magnitude_top3_peaks.sv]
//==============================================================================
// spectrum_magnitude_top3_peaks
// Per-bin magnitude of packed FFT words with a top-3 peak search per frame.
//
// Input queue side: bin_data is taken when push is high and full is low.
// Bins are numbered from 0 within a frame; last_bin, or reaching bin
// min(FFT_POINTS/2, 512) - 1, ends the frame. Bin 0 is left out of the search.
// Result queue side: result holds the oldest result while empty is low and
// is taken when pop is high. One result per bin; on the frame end it carries
// the three peak bins and the largest magnitude.
// The back end handles one bin at a time: squaring, summing, the 17-step
// bit-serial square root and a write-out step; it takes the next bin only
// once the last one is written out.
// A two-entry queue lets up to two bins wait while the back end works; a
// result register holds the finished bin while pop is low, and the back end
// waits in its write step until the result is taken.
// Reset clears the bin counter, the peak tracker, the queue and the
// result valid flag; no result is pending after reset.
//==============================================================================
`default_nettype none

module spectrum_magnitude_top3_peaks
    import smt3p_pkg::*;
#(
    parameter int FFT_POINTS = FFT_POINTS_DEFAULT
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire spec_in_t bin_data,
    output logic          empty,
    input  wire logic     pop,
    output spec_out_t     result
);

    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;
    bin_task_t q_wr_entry;
    bin_task_t q_rd_entry;

    smt3p_front #(
        .FFT_POINTS (FFT_POINTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .bin_data (bin_data),
        .q_push   (q_push),
        .q_entry  (q_wr_entry),
        .q_full   (q_full)
    );

    smt3p_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_entry),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_entry),
        .q_empty (q_empty)
    );

    smt3p_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_entry (q_rd_entry),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    a_peaks_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.frame_done) |->
            (result.first_peak_bin == '0 && result.second_peak_bin == '0 &&
             result.third_peak_bin == '0 && result.first_peak_magnitude == '0))
        else $error("peak fields set on a result that does not end the frame");

    a_no_peak_no_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.frame_done && result.first_peak_magnitude == '0) |->
            (result.first_peak_bin == '0 && result.second_peak_bin == '0))
        else $error("peak bin reported without a nonzero peak");

    a_peaks_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.frame_done && result.second_peak_bin != '0) |->
            (result.first_peak_bin != '0 &&
             result.first_peak_bin != result.second_peak_bin))
        else $error("second peak present without a distinct first peak");

    a_queue_pop_when_filled: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !q_empty)
        else $error("queue reports full and empty together");

endmodule

`default_nettype wire

[hdl/smt3p_front.sv]
//==============================================================================
// smt3p_front
// Accepts bins, numbers them within the frame and flags the frame end.
//==============================================================================
`default_nettype none

module smt3p_front
    import smt3p_pkg::*;
#(
    parameter int FFT_POINTS = FFT_POINTS_DEFAULT
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire spec_in_t  bin_data,
    output logic           q_push,
    output bin_task_t      q_entry,
    input  wire logic      q_full
);

    localparam int HALF_PTS  = FFT_POINTS / 2;
    localparam int CAP_PTS   = (HALF_PTS > MAX_BINS) ? MAX_BINS : HALF_PTS;
    localparam logic [BIN_W-1:0] FINAL_BIN = BIN_W'(CAP_PTS - 1);

    logic [BIN_W-1:0] bin_cnt_reg;
    logic [BIN_W-1:0] bin_cnt_next;
    logic             done;

    assign full   = q_full;
    assign q_push = push && !q_full;
    assign done   = bin_data.last_bin || (bin_cnt_reg == FINAL_BIN);

    assign q_entry.spectrum_word = bin_data.spectrum_word;
    assign q_entry.bin           = bin_cnt_reg;
    assign q_entry.done          = done;

    always_comb
    begin
        bin_cnt_next = bin_cnt_reg;
        if (q_push)
        begin
            bin_cnt_next = done ? '0 : bin_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_cnt_reg <= '0;
        end
        else
        begin
            bin_cnt_reg <= bin_cnt_next;
        end
    end

endmodule

`default_nettype wire

[hdl/smt3p_queue.sv]
//==============================================================================
// smt3p_queue
// Two-entry queue between the front and the back.
//==============================================================================
`default_nettype none

module smt3p_queue
    import smt3p_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  wire bin_task_t wr_data,
    output logic           q_full,
    input  wire logic      rd_en,
    output bin_task_t      rd_data,
    output logic           q_empty
);

    bin_task_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_wr;
    logic       do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/smt3p_back.sv]
//==============================================================================
// smt3p_back
// Squares, bit-serial square root, top-3 tracker and result register.
//==============================================================================
`default_nettype none

module smt3p_back
    import smt3p_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_empty,
    output logic           q_pop,
    input  wire bin_task_t q_entry,
    output logic           empty,
    input  wire logic      pop,
    output spec_out_t      result
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SQUARE = 5'b00010,
        ST_SUM    = 5'b00100,
        ST_ROOT   = 5'b01000,
        ST_WRITE  = 5'b10000
    } back_state_t;

    back_state_t state_reg, state_next;

    bin_task_t         task_reg;
    logic [SQ_W-1:0]   sq_lo_reg;
    logic [SQ_W-1:0]   sq_hi_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [MAG_W-1:0]  root_reg;
    logic [STEP_W-1:0] step_reg;

    logic [MAG_W-1:0]  best_mag_reg, second_mag_reg, third_mag_reg;
    logic [BIN_W-1:0]  best_bin_reg, second_bin_reg, third_bin_reg;
    logic [MAG_W-1:0]  best_mag_next, second_mag_next, third_mag_next;
    logic [BIN_W-1:0]  best_bin_next, second_bin_next, third_bin_next;

    spec_out_t         out_reg;
    logic              out_valid_reg;

    logic signed [HALF_W-1:0]   lo_s, hi_s;
    logic signed [2*HALF_W-1:0] lo_prod, hi_prod;
    logic [SUM_W-1:0]           sq_sum;
    logic [REM_W+1:0]           rem_shift;
    logic [REM_W+1:0]           trial;
    logic                       root_bit;
    logic                       out_free;
    logic                       write_out;

    assign lo_s    = task_reg.spectrum_word[HALF_W-1:0];
    assign hi_s    = task_reg.spectrum_word[WORD_W-1:HALF_W];
    assign lo_prod = lo_s * lo_s;
    assign hi_prod = hi_s * hi_s;
    assign sq_sum  = SUM_W'(sq_lo_reg) + SUM_W'(sq_hi_reg);

    assign rem_shift = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial     = (REM_W+2)'({root_reg, 2'b01});
    assign root_bit  = (rem_shift >= trial);

    assign out_free  = !out_valid_reg || pop;
    assign write_out = (state_reg == ST_WRITE) && out_free;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (!q_empty) state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_SUM;
            ST_SUM:    state_next = ST_ROOT;
            ST_ROOT:   if (step_reg == STEP_W'(1)) state_next = ST_WRITE;
            ST_WRITE:  if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // top-3 insertion, strict compare keeps the earlier bin on ties
    always_comb
    begin
        best_mag_next   = best_mag_reg;
        second_mag_next = second_mag_reg;
        third_mag_next  = third_mag_reg;
        best_bin_next   = best_bin_reg;
        second_bin_next = second_bin_reg;
        third_bin_next  = third_bin_reg;
        if (task_reg.bin != '0)
        begin
            priority if (root_reg > best_mag_reg)
            begin
                third_mag_next  = second_mag_reg;
                third_bin_next  = second_bin_reg;
                second_mag_next = best_mag_reg;
                second_bin_next = best_bin_reg;
                best_mag_next   = root_reg;
                best_bin_next   = task_reg.bin;
            end
            else if (root_reg > second_mag_reg)
            begin
                third_mag_next  = second_mag_reg;
                third_bin_next  = second_bin_reg;
                second_mag_next = root_reg;
                second_bin_next = task_reg.bin;
            end
            else if (root_reg > third_mag_reg)
            begin
                third_mag_next = root_reg;
                third_bin_next = task_reg.bin;
            end
            else
            begin
                third_mag_next = third_mag_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            task_reg <= q_entry;
        end
        if (state_reg == ST_SQUARE)
        begin
            sq_lo_reg <= SQ_W'(lo_prod);
            sq_hi_reg <= SQ_W'(hi_prod);
        end
        if (state_reg == ST_SUM)
        begin
            rad_reg  <= {sq_sum, 2'b00};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (state_reg == ST_ROOT)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= root_bit ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
            root_reg <= {root_reg[MAG_W-2:0], root_bit};
        end
        if (write_out)
        begin
            out_reg.magnitude  <= root_reg;
            out_reg.bin_index  <= task_reg.bin;
            out_reg.frame_done <= task_reg.done;
            if (task_reg.done)
            begin
                out_reg.first_peak_bin       <= best_bin_next;
                out_reg.second_peak_bin      <= second_bin_next;
                out_reg.third_peak_bin       <= third_bin_next;
                out_reg.first_peak_magnitude <= best_mag_next;
            end
            else
            begin
                out_reg.first_peak_bin       <= '0;
                out_reg.second_peak_bin      <= '0;
                out_reg.third_peak_bin       <= '0;
                out_reg.first_peak_magnitude <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            best_mag_reg   <= '0;
            second_mag_reg <= '0;
            third_mag_reg  <= '0;
            best_bin_reg   <= '0;
            second_bin_reg <= '0;
            third_bin_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SUM)
            begin
                step_reg <= STEP_W'(ROOT_STEPS);
            end
            else if (state_reg == ST_ROOT)
            begin
                step_reg <= step_reg - 1'b1;
            end
            if (write_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (write_out)
            begin
                if (task_reg.done)
                begin
                    best_mag_reg   <= '0;
                    second_mag_reg <= '0;
                    third_mag_reg  <= '0;
                    best_bin_reg   <= '0;
                    second_bin_reg <= '0;
                    third_bin_reg  <= '0;
                end
                else
                begin
                    best_mag_reg   <= best_mag_next;
                    second_mag_reg <= second_mag_next;
                    third_mag_reg  <= third_mag_next;
                    best_bin_reg   <= best_bin_next;
                    second_bin_reg <= second_bin_next;
                    third_bin_reg  <= third_bin_next;
                end
            end
        end
    end

endmodule

`default_nettype wire
